[rtl/wti_pkg.sv]
// Package for the waypoint trajectory interpolator: sizes, command and status codes.
// Used by all modules of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wti_pkg;
  localparam int MaxWaypoints = 64;
  localparam int MaxJoints    = 8;
  localparam int WpW          = $clog2(MaxWaypoints);
  localparam int JW           = $clog2(MaxJoints);
  localparam int CntW         = $clog2(MaxWaypoints + 1);
  localparam int PosAw        = WpW + JW;
  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef enum logic [1:0] {
    CmdTime = 2'd0,
    CmdPos  = 2'd1,
    CmdEval = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StInterp = 2'd0,
    StHeld   = 2'd1,
    StNoTraj = 2'd2,
    StRsvd   = 2'd3
  } status_e;

  localparam logic [1:0] RegReady = 2'd0;
  localparam logic [1:0] RegCount = 2'd1;
  localparam logic [1:0] RegJoints = 2'd2;
endpackage
`default_nettype wire

[rtl/waypoint_trajectory_interpolator_core.sv]
// Top level of the waypoint trajectory interpolator: tables, search, divider, lerp.
// Depends on wti_pkg.
//
// Input channel (valid/ready) carries write-time, write-position and evaluate
// commands. Writes take one transfer each, can follow back to back and produce
// nothing. An evaluation scans the time table one entry at a time through the
// states T0 and SCAN, then runs a 17-bit restoring divider (33 quotient bits),
// then reads two positions per joint (one when the result is held at a
// waypoint) and emits one result per joint. An evaluation with no trajectory
// ready emits a single no-trajectory result. One evaluation is in flight at a
// time; the next item is accepted once the last result is in the output
// register. Results leave through a single output register; a stalled receiver
// holds the current result and the sequencer waits. Reset clears the
// configuration registers (joint_count to 1) and the control state; the tables
// are not cleared and must be written before they are read. Configuration must
// be written by the user through the APB port only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_trajectory_interpolator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [5:0] waypoint_index_i,
  input  wire logic [2:0] joint_index_i,
  input  wire logic [16:0] time_value_i,
  input  wire logic signed [23:0] position_value_i,
  input  wire logic [16:0] progress_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [2:0] joint_number_o,
  output logic signed [23:0] position_o,
  output logic [1:0] status_o,
  output logic last_o
);
  import wti_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T0   = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_TA   = 4'd3;
  localparam logic [3:0] S_TB   = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RA   = 4'd6;
  localparam logic [3:0] S_RB   = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_WAIT = 4'd10;

  logic [16:0] time_mem [MaxWaypoints];
  logic signed [23:0] pos_mem [MaxWaypoints * MaxJoints];

  logic ready_q;
  logic [6:0] count_q;
  logic [3:0] joints_q;
  logic [3:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, i_q;
  logic [JW:0] nj_q, j_q;
  logic [16:0] prog_q, t0_q, den_q;
  logic [16:0] tdat_q;
  logic signed [23:0] pdat_q, a_q;
  logic held_q;
  logic [WpW-1:0] hold_q;
  logic [33:0] rem_q;
  logic [32:0] num_q;
  logic [16:0] frac_q;
  logic [5:0] dcnt_q;
  logic signed [41:0] prod_q;
  logic [WpW-1:0] traddr;
  logic [PosAw-1:0] praddr;
  logic tre, pre;

  wire wr_en = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      count_q <= '0;
      joints_q <= 4'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegReady: ready_q <= pwdata[0];
        RegCount: count_q <= pwdata[6:0];
        RegJoints: joints_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      RegReady: prdata = {31'd0, ready_q};
      RegCount: prdata = {25'd0, count_q};
      RegJoints: prdata = {28'd0, joints_q};
      default: prdata = '0;
    endcase
  end

  assign in_ready_o = (st_q == S_IDLE);
  wire acc = in_valid_i && in_ready_o;
  wire out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (acc && command_i == CmdTime) time_mem[waypoint_index_i] <= time_value_i;
    if (tre) tdat_q <= time_mem[traddr];
  end
  always_ff @(posedge clk_i) begin
    if (acc && command_i == CmdPos) pos_mem[{waypoint_index_i, joint_index_i}] <= position_value_i;
    if (pre) pdat_q <= pos_mem[praddr];
  end

  wire [WpW-1:0] i_w = i_q[WpW-1:0];
  wire [WpW-1:0] i1_w = i_w + 1'b1;
  wire [JW-1:0] j_w = j_q[JW-1:0];
  always_comb begin
    tre = 1'b0;
    traddr = i1_w;
    pre = 1'b0;
    praddr = {i_w, j_w};
    unique case (st_q)
      S_T0: tre = 1'b1;
      S_SCAN: tre = 1'b1;
      S_TA: begin
        tre = 1'b1;
        traddr = i_w;
      end
      S_RA: begin
        pre = 1'b1;
        praddr = held_q ? {hold_q, j_w} : {i_w, j_w};
      end
      S_RB: begin
        pre = 1'b1;
        praddr = {i1_w, j_w};
      end
      default: ;
    endcase
  end

  wire [CntW-1:0] cnt_sat = (count_q > 7'(MaxWaypoints)) ? CntW'(MaxWaypoints)
                                                         : CntW'(count_q);
  wire [JW:0] nj_sat = (joints_q == 4'd0) ? (JW+1)'(1) :
                       (joints_q > 4'(MaxJoints)) ? (JW+1)'(MaxJoints) : (JW+1)'(joints_q);
  wire [34:0] rem_sh = {rem_q, num_q[32]};
  wire [34:0] rem_sub = rem_sh - {18'd0, den_q};
  wire signed [24:0] diff = pdat_q - a_q;
  wire signed [42:0] rsum = {{19{a_q[23]}}, a_q} + 43'(prod_q >>> 16);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (acc && command_i == CmdEval) begin
        if (!ready_q || cnt_sat == '0) st_d = S_WAIT;
        else if (cnt_sat == CntW'(1)) st_d = S_RA;
        else st_d = S_T0;
      end
      S_T0: st_d = S_SCAN;
      S_SCAN: begin
        if (tdat_q > prog_q) st_d = S_TA;
        else if (i_q + 2'd2 >= cnt_q) st_d = S_RA;
        else st_d = S_T0;
      end
      S_TA: st_d = S_TB;
      S_TB: st_d = S_DIV;
      S_DIV: if (dcnt_q == '0) st_d = S_RA;
      S_RA: st_d = held_q ? S_MUL : S_RB;
      S_RB: st_d = S_MUL;
      S_MUL: st_d = S_OUT;
      S_OUT: if (out_free) st_d = (j_q + 1'b1 == nj_q) ? S_IDLE : S_RA;
      S_WAIT: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if ((st_q == S_OUT || st_q == S_WAIT) && out_free) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        cnt_q <= cnt_sat;
        nj_q <= nj_sat;
        prog_q <= (progress_i > OneQ16) ? OneQ16 : progress_i;
        i_q <= '0;
        j_q <= '0;
        held_q <= (cnt_sat == CntW'(1));
        hold_q <= '0;
        frac_q <= '0;
      end
      S_SCAN: begin
        if (tdat_q <= prog_q) begin
          i_q <= i_q + 1'b1;
          if (i_q + 2'd2 >= cnt_q) begin
            held_q <= 1'b1;
            hold_q <= WpW'(cnt_q - 1'b1);
          end
        end
      end
      S_TB: t0_q <= tdat_q;
      S_DIV: begin
        if (dcnt_q == 6'd34) begin
          if (den_q > t0_q && prog_q >= t0_q) begin
            den_q <= den_q - t0_q;
            num_q <= {prog_q - t0_q, 16'd0};
            rem_q <= '0;
            dcnt_q <= 6'd33;
          end else dcnt_q <= '0;
        end else if (dcnt_q != '0) begin
          num_q <= {num_q[31:0], 1'b0};
          if (!rem_sub[34]) begin
            rem_q <= rem_sub[33:0];
            frac_q <= (frac_q == OneQ16 || {frac_q, 1'b1} > {1'b0, OneQ16}) ? OneQ16
                      : {frac_q[15:0], 1'b1};
          end else begin
            rem_q <= rem_sh[33:0];
            frac_q <= ({frac_q, 1'b0} > {1'b0, OneQ16}) ? OneQ16 : {frac_q[15:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 1'b1;
        end
      end
      S_RB: a_q <= pdat_q;
      S_MUL: prod_q <= $signed({1'b0, frac_q}) * diff + 42'sd32768;
      S_OUT: if (out_free) j_q <= j_q + 1'b1;
      default: ;
    endcase
    if (st_q == S_TA) begin
      den_q <= tdat_q;
      dcnt_q <= 6'd34;
    end
    if ((st_q == S_OUT || st_q == S_WAIT) && out_free) begin
      if (st_q == S_WAIT) begin
        joint_number_o <= '0;
        position_o <= '0;
        status_o <= StNoTraj;
        last_o <= 1'b1;
      end else begin
        joint_number_o <= 3'(j_q);
        status_o <= held_q ? StHeld : StInterp;
        last_o <= (j_q + 1'b1 == nj_q);
        if (held_q) position_o <= pdat_q;
        else if (rsum > 43'sd8388607) position_o <= 24'sh7FFFFF;
        else if (rsum < -43'sd8388608) position_o <= -24'sh800000;
        else position_o <= rsum[23:0];
      end
    end
  end

`ifndef SYNTH
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(position_o))
    else $error("result dropped");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> dcnt_q <= 6'd34) else $error("divider count");
  a_frac_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_MUL) |-> frac_q <= OneQ16) else $error("fraction range");
`endif
endmodule
`default_nettype wire
